// ===== src/mrf_pkg.sv =====
package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int BYTE_IDX_W = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]  server_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] reg_value;
    } req_t;

    typedef struct packed {
        logic pop;
    } eng_stat_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

// ===== src/mrf_req_queue.sv =====
module mrf_req_queue #(
    parameter int Depth = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrf_pkg::req_t     push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [$clog2(Depth+1)-1:0] count,
    output mrf_pkg::req_t     head
);
    import mrf_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    req_t entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CntW'(Depth));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/mrf_byte_engine.sv =====
module mrf_byte_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_present,
    input  mrf_pkg::req_t       req,
    output mrf_pkg::eng_stat_t  stat,
    output logic                byte_valid,
    input  logic                byte_stall,
    output logic [7:0]          frame_byte,
    output logic                last_byte
);
    import mrf_pkg::*;

    localparam logic [BYTE_IDX_W-1:0] IDX_ADDR   = BYTE_IDX_W'(0);
    localparam logic [BYTE_IDX_W-1:0] IDX_FUNC   = BYTE_IDX_W'(1);
    localparam logic [BYTE_IDX_W-1:0] IDX_REG_HI = BYTE_IDX_W'(2);
    localparam logic [BYTE_IDX_W-1:0] IDX_REG_LO = BYTE_IDX_W'(3);
    localparam logic [BYTE_IDX_W-1:0] IDX_VAL_HI = BYTE_IDX_W'(4);
    localparam logic [BYTE_IDX_W-1:0] IDX_VAL_LO = BYTE_IDX_W'(5);
    localparam logic [BYTE_IDX_W-1:0] IDX_CRC_LO = BYTE_IDX_W'(6);
    localparam logic [BYTE_IDX_W-1:0] IDX_CRC_HI = BYTE_IDX_W'(7);

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [7:0]  byte_sel;
    logic        advance;

    assign advance = req_present && (!valid_reg || !byte_stall);

    always_comb
    begin
        unique case (idx_reg)
            IDX_ADDR:   byte_sel = req.server_address;
            IDX_FUNC:   byte_sel = req.function_code;
            IDX_REG_HI: byte_sel = req.register_address[15:8];
            IDX_REG_LO: byte_sel = req.register_address[7:0];
            IDX_VAL_HI: byte_sel = req.reg_value[15:8];
            IDX_VAL_LO: byte_sel = req.reg_value[7:0];
            IDX_CRC_LO: byte_sel = crc_reg[7:0];
            IDX_CRC_HI: byte_sel = crc_reg[15:8];
            default:    byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (advance)
        begin
            idx_next   = (idx_reg == IDX_CRC_HI) ? IDX_ADDR : idx_reg + 1'b1;
            if (idx_reg < IDX_CRC_LO)
            begin
                crc_next = crc_update((idx_reg == IDX_ADDR) ? CRC_INIT : crc_reg, byte_sel);
            end
            valid_next = 1'b1;
            byte_next  = byte_sel;
            last_next  = (idx_reg == IDX_CRC_HI);
        end
        else if (!byte_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= IDX_ADDR;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg  <= crc_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign stat.pop      = advance && (idx_reg == IDX_CRC_HI);
    assign byte_valid    = valid_reg;
    assign frame_byte    = byte_reg;
    assign last_byte     = last_reg;

endmodule

// ===== src/modbus_rtu_request_framer_core.sv =====
// Modbus RTU request framer.
// The request channel (req_valid, req_stall) carries one request per transfer:
// server_address, function_code, register_address and reg_value.
// The byte channel (byte_valid, byte_stall) returns the eight frame bytes in
// transmit order: address, function, register high and low, value high and
// low, then the CRC-16/Modbus low byte and high byte, the last with last_byte set.
// Requests enter a short queue that is read by a byte engine; req_stall is
// high only while that queue is full.
// When the queue was empty, a request is first written into the queue and its
// first byte is then loaded into the output register. The engine emits one byte
// per cycle while the output is not stalled, folding each body byte into the CRC
// as it goes, and frames follow each other with no gap while requests are queued.
// A stalled output holds its byte and the engine waits; further requests
// collect in the queue until it is full.
// Reset empties the queue and the output register and restarts the byte count.
module modbus_rtu_request_framer_core #(
    parameter int QueueDepth = mrf_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [7:0]  server_address,
    input  logic [7:0]  function_code,
    input  logic [15:0] register_address,
    input  logic [15:0] reg_value,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);
    import mrf_pkg::*;

    req_t      in_req;
    req_t      head_req;
    eng_stat_t eng_stat;
    logic      q_full;
    logic      q_not_empty;
    logic [$clog2(QueueDepth+1)-1:0] q_count;

    assign in_req.server_address   = server_address;
    assign in_req.function_code    = function_code;
    assign in_req.register_address = register_address;
    assign in_req.reg_value        = reg_value;
    assign req_stall               = q_full;

    mrf_req_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (req_valid),
        .push_data(in_req),
        .pop      (eng_stat.pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .count    (q_count),
        .head     (head_req)
    );

    mrf_byte_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_present(q_not_empty),
        .req        (head_req),
        .stat       (eng_stat),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
        else $error("Request queue count exceeds its depth.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.pop |-> q_not_empty)
        else $error("Byte engine released a request from an empty queue.");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.pop |=> (byte_valid && last_byte))
        else $error("Request release was not followed by the last frame byte.");

endmodule
